### hdl/jep_pkg.sv
package jep_pkg;

   // iteration limit and fixed-point format
   localparam int MAX_ITERATIONS = 100;
   localparam int ITER_W         = $clog2(MAX_ITERATIONS + 1);
   localparam int FRAC_BITS      = 26;
   localparam int COORD_W        = 32;
   localparam int PROD_W         = 2 * COORD_W;
   localparam int SAT_W          = 48;

   // field widths
   localparam int PIXEL_W        = 10;
   localparam int SIZE_W         = 11;
   localparam int STEP_W         = 31;
   localparam int OFFSET_W       = 10;
   localparam int SCREEN_W       = 11;
   localparam int ITERATIONS_W   = 7;
   localparam int COLOR_W        = 5;

   // stream and register port widths
   localparam int REQ_DATA_W     = 24;
   localparam int RSP_DATA_W     = 40;
   localparam int RSP_PAD_W      = RSP_DATA_W - 2 * SCREEN_W - ITERATIONS_W - COLOR_W;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 32;

   // queue between front and back
   localparam int QUEUE_DEPTH    = 2;
   localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCOUNT_W       = $clog2(QUEUE_DEPTH + 1);

   // escape radius squared (4.0) in the exact product format
   localparam logic [PROD_W-1:0] ESCAPE_LIMIT = PROD_W'(1) << (2 * FRAC_BITS + 2);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CONST_REAL   = 3'd0,
      CSR_CONST_IMAG   = 3'd1,
      CSR_PIXEL_STEP   = 3'd2,
      CSR_FRAME_WIDTH  = 3'd3,
      CSR_FRAME_HEIGHT = 3'd4,
      CSR_X_OFFSET     = 3'd5,
      CSR_Y_OFFSET     = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] const_real;
      logic signed [COORD_W-1:0] const_imag;
      logic [STEP_W-1:0]         pixel_step;
      logic [SIZE_W-1:0]         frame_width;
      logic [SIZE_W-1:0]         frame_height;
      logic [OFFSET_W-1:0]       x_offset;
      logic [OFFSET_W-1:0]       y_offset;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      const_real:   -32'sd23488102,
      const_imag:   32'sd43620762,
      pixel_step:   31'd536871,
      frame_width:  11'd320,
      frame_height: 11'd200,
      x_offset:     10'd0,
      y_offset:     10'd0
   };

   // one pixel job handed from front to back
   typedef struct packed {
      logic signed [COORD_W-1:0] x0;
      logic signed [COORD_W-1:0] y0;
      logic [SCREEN_W-1:0]       screen_x;
      logic [SCREEN_W-1:0]       screen_y;
   } job_type;

   typedef struct packed {
      logic [SCREEN_W-1:0]     screen_x;
      logic [SCREEN_W-1:0]     screen_y;
      logic [ITERATIONS_W-1:0] iterations;
      logic [COLOR_W-1:0]      color;
   } result_type;

   typedef struct packed {
      logic                full;
      logic                empty;
      logic [QCOUNT_W-1:0] count;
   } queue_status_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_X,
      FRONT_Y
   } front_state_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_MUL,
      BACK_UPD,
      BACK_DONE
   } back_state_type;

   // palette index per iteration count, built at elaboration
   typedef logic [COLOR_W-1:0] color_table_type [0:MAX_ITERATIONS];

   function automatic color_table_type make_color_table();
      color_table_type t;
      for (int i = 0; i <= MAX_ITERATIONS; i++) begin
         t[i] = COLOR_W'((i * 15) / MAX_ITERATIONS + 16);
      end
      return t;
   endfunction

   localparam color_table_type COLOR_TABLE = make_color_table();

   // clamp a wide signed value to the coordinate range
   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SAT_W-1:0] v);
      logic signed [COORD_W-1:0] r;
      if (&v[SAT_W-1:COORD_W-1] || ~|v[SAT_W-1:COORD_W-1]) begin
         r = v[COORD_W-1:0];
      end else if (v[SAT_W-1]) begin
         r = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(COORD_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

### hdl/jep_front.sv
module jep_front
   import jep_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  q_push,
   output job_type               q_wdata,
   input  queue_status_type      q_status
);

   front_state_type state_ff, state_in;

   logic [PIXEL_W-1:0]        col_ff, row_ff;
   logic [SCREEN_W-1:0]       sx_ff, sy_ff;
   logic signed [COORD_W-1:0] x0_ff;

   logic [PIXEL_W-1:0]        req_col, req_row;
   logic [PIXEL_W-1:0]        idx;
   logic [SIZE_W-1:0]         size;
   logic signed [12:0]        diff;
   logic signed [44:0]        prod;
   logic signed [44:0]        half;
   logic signed [COORD_W-1:0] coord_sat;
   logic                      accept;

   assign req_col = req_tdata[PIXEL_W-1:0];
   assign req_row = req_tdata[2*PIXEL_W-1:PIXEL_W];
   assign accept  = req_tvalid && req_tready;

   // start coordinate: floor((2*idx - size) * step / 2), one axis per cycle, y held while the queue is full
   assign idx       = (state_ff == FRONT_X) ? col_ff : row_ff;
   assign size      = (state_ff == FRONT_X) ? cfg.frame_width : cfg.frame_height;
   assign diff      = $signed({2'b00, idx, 1'b0}) - $signed({2'b00, size});
   assign prod      = diff * $signed({1'b0, cfg.pixel_step});
   assign half      = prod >>> 1;
   assign coord_sat = sat_coord({{(SAT_W-45){half[44]}}, half});

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FRONT_IDLE: begin
            if (req_tvalid) state_in = FRONT_X;
         end
         FRONT_X: begin
            state_in = FRONT_Y;
         end
         FRONT_Y: begin
            if (!q_status.full) state_in = FRONT_IDLE;
         end
         default: begin
            state_in = FRONT_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_tready = (state_ff == FRONT_IDLE);
      q_push     = (state_ff == FRONT_Y) && !q_status.full;
   end

   assign q_wdata = '{x0: x0_ff, y0: coord_sat, screen_x: sx_ff, screen_y: sy_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // request capture and real-axis start point
   always_ff @(posedge clock) begin
      if (accept) begin
         col_ff <= req_col;
         row_ff <= req_row;
         sx_ff  <= {1'b0, req_col} + {1'b0, cfg.x_offset};
         sy_ff  <= {1'b0, req_row} + {1'b0, cfg.y_offset};
      end
      if (state_ff == FRONT_X) begin
         x0_ff <= coord_sat;
      end
   end

endmodule

### hdl/jep_queue.sv
module jep_queue
   import jep_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          wdata,
   input  logic             pop,
   output job_type          rdata,
   output queue_status_type status
);

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0] count_ff, count_in;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

   assign rdata        = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QCOUNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign status.count = count_ff;

endmodule

### hdl/jep_back.sv
module jep_back
   import jep_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   output logic              q_pop,
   input  job_type           q_rdata,
   input  queue_status_type  q_status,
   output logic              res_valid,
   output result_type        res_data,
   input  logic              res_take,
   output logic [ITER_W-1:0] iter
);

   back_state_type state_ff, state_in;

   logic signed [COORD_W-1:0] x_ff, y_ff;
   logic signed [PROD_W-1:0]  xx_ff, yy_ff, xy_ff;
   logic [ITER_W-1:0]         it_ff;
   logic [SCREEN_W-1:0]       sx_ff, sy_ff;

   logic [PROD_W-1:0]         mag;
   logic                      escaped;
   logic                      at_limit;
   logic                      finish;
   logic signed [PROD_W-1:0]  xx_sh, yy_sh, xy_sh;
   logic signed [SAT_W-1:0]   cr_ext, ci_ext;
   logic signed [SAT_W-1:0]   x_sum, y_sum;

   // escape test on the exact squares, then the step in Q6.26
   assign mag      = xx_ff + yy_ff;
   assign escaped  = (mag >= ESCAPE_LIMIT);
   assign at_limit = (it_ff == ITER_W'(MAX_ITERATIONS));
   assign finish   = escaped || at_limit;

   assign xx_sh  = xx_ff >>> FRAC_BITS;
   assign yy_sh  = yy_ff >>> FRAC_BITS;
   assign xy_sh  = xy_ff >>> (FRAC_BITS - 1);
   assign cr_ext = {{(SAT_W-COORD_W){cfg.const_real[COORD_W-1]}}, cfg.const_real};
   assign ci_ext = {{(SAT_W-COORD_W){cfg.const_imag[COORD_W-1]}}, cfg.const_imag};
   assign x_sum  = xx_sh[SAT_W-1:0] - yy_sh[SAT_W-1:0] + cr_ext;
   assign y_sum  = xy_sh[SAT_W-1:0] + ci_ext;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (!q_status.empty) state_in = BACK_MUL;
         end
         BACK_MUL: begin
            state_in = BACK_UPD;
         end
         BACK_UPD: begin
            state_in = finish ? BACK_DONE : BACK_MUL;
         end
         BACK_DONE: begin
            if (res_take) state_in = BACK_IDLE;
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      q_pop     = (state_ff == BACK_IDLE) && !q_status.empty;
      res_valid = (state_ff == BACK_DONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // iteration datapath
   always_ff @(posedge clock) begin
      if (q_pop) begin
         x_ff  <= q_rdata.x0;
         y_ff  <= q_rdata.y0;
         sx_ff <= q_rdata.screen_x;
         sy_ff <= q_rdata.screen_y;
      end
      if (state_ff == BACK_MUL) begin
         xx_ff <= x_ff * x_ff;
         yy_ff <= y_ff * y_ff;
         xy_ff <= x_ff * y_ff;
      end
      if (state_ff == BACK_UPD && !finish) begin
         x_ff  <= sat_coord(x_sum);
         y_ff  <= sat_coord(y_sum);
      end
   end

   // step counter, cleared at reset and at each new job
   always_ff @(posedge clock) begin
      if (reset) begin
         it_ff <= '0;
      end else if (q_pop) begin
         it_ff <= '0;
      end else if (state_ff == BACK_UPD && !finish) begin
         it_ff <= it_ff + 1'b1;
      end
   end

   assign res_data = '{
      screen_x:   sx_ff,
      screen_y:   sy_ff,
      iterations: ITERATIONS_W'(it_ff),
      color:      COLOR_TABLE[it_ff]
   };
   assign iter = it_ff;

endmodule

### hdl/julia_escape_time_pixel.sv
// Julia set escape-time unit, one pixel per request.
// req channel: a request carries pixel_col and pixel_row; the front end maps it to a
//    complex start point (one multiplier, one axis per unstalled cycle) and queues the job.
// rsp channel: one result per request, in request order, with screen position,
//    iteration count and palette color.
// csr port: csr_we writes csr_wdata into the register selected by csr_index at the
//    clock edge; write only while no request is outstanding.
// Timing: the front end takes a new request only after it has queued the previous job. The
//    back end runs each escape step as BACK_MUL (the three 32x32 products), then BACK_UPD
//    (the escape test and update); rsp_tvalid is driven from the output register.
// A two-entry job queue lets the front end take new requests while the back end works.
// The result sits in an output register; while rsp_tready is low it holds, the back
//    end waits with its finished result, and the queue then the front end fill and stall.
// Reset (synchronous) empties the queue, drops any pending result and loads the
//    register defaults.
module julia_escape_time_pixel
   import jep_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request: pixel_col [9:0], pixel_row [19:10]
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // result: screen_x [10:0], screen_y [21:11], iterations [28:22], color [33:29]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type           cfg_ff, cfg_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff;

   logic              q_push, q_pop;
   job_type           q_wdata, q_rdata;
   queue_status_type  q_status;
   logic              res_valid;
   result_type        res_data;
   logic              out_free;
   logic [ITER_W-1:0] back_iter;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CONST_REAL:   cfg_in.const_real   = $signed(csr_wdata);
            CSR_CONST_IMAG:   cfg_in.const_imag   = $signed(csr_wdata);
            CSR_PIXEL_STEP:   cfg_in.pixel_step   = csr_wdata[STEP_W-1:0];
            CSR_FRAME_WIDTH:  cfg_in.frame_width  = csr_wdata[SIZE_W-1:0];
            CSR_FRAME_HEIGHT: cfg_in.frame_height = csr_wdata[SIZE_W-1:0];
            CSR_X_OFFSET:     cfg_in.x_offset     = csr_wdata[OFFSET_W-1:0];
            CSR_Y_OFFSET:     cfg_in.y_offset     = csr_wdata[OFFSET_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   jep_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_push     (q_push),
      .q_wdata    (q_wdata),
      .q_status   (q_status)
   );

   jep_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wdata  (q_wdata),
      .pop    (q_pop),
      .rdata  (q_rdata),
      .status (q_status)
   );

   jep_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_pop     (q_pop),
      .q_rdata   (q_rdata),
      .q_status  (q_status),
      .res_valid (res_valid),
      .res_data  (res_data),
      .res_take  (out_free),
      .iter      (back_iter)
   );

   // output register
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && out_free) begin
         rsp_ff <= res_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_ff.color, rsp_ff.iterations,
                        rsp_ff.screen_y, rsp_ff.screen_x};

   // checks
   a_front_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("front end took a request while busy");

   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full || q_pop)
      else $error("job pushed into a full queue");

   a_queue_count_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= QCOUNT_W'(QUEUE_DEPTH))
      else $error("queue fill count beyond depth");

   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      back_iter <= ITER_W'(MAX_ITERATIONS))
      else $error("iteration count beyond limit");

endmodule
